/* hw/rtl/mi_pkg.sv */
// Package: widths, status codes and shared types for the modular inverse block.
package mi_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_INV = 1'b1;

  typedef struct packed {
    logic load;
  } mi_step_ctrl_t;

  typedef struct packed {
    logic done;
  } mi_step_stat_t;

endpackage

/* hw/rtl/modular_inverse.sv */
// Top level: modular inverse by the extended Euclidean algorithm.
// Accepts value and modulus when start is high and busy is low, then stays busy until the
// single result appears on inverse and status for one cycle with done high; the result
// cannot be held off, so capture it on that cycle. The sequencer drives one shared
// shift-subtract unit through the Euclid remainder sequence, plus one leading step that
// reduces value modulo modulus. The align and subtract passes of that unit each work one bit
// per cycle. A zero modulus finishes without a Euclid step. status is 0 with the inverse in
// 0 .. modulus-1, or 1 with inverse 0 when the gcd is not one or the modulus is zero.
module modular_inverse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [mi_pkg::WIDTH-1:0]  value,
  input  logic [mi_pkg::WIDTH-1:0]  modulus,
  output logic                      done,
  output logic [mi_pkg::WIDTH-1:0]  inverse,
  output logic                      status
);
  import mi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_WAIT,
    S_FIN1,
    S_FIN2
  } state_t;

  state_t            state;
  logic [WIDTH-1:0]  m;
  logic [WIDTH-1:0]  r0;
  logic [WIDTH-1:0]  r1;
  logic [WIDTH-1:0]  t0;
  logic [WIDTH-1:0]  t1;
  logic              neg0;
  logic [WIDTH-1:0]  inv;
  mi_step_ctrl_t     ctrl;
  mi_step_stat_t     stat;
  logic [WIDTH-1:0]  rem;
  logic [WIDTH-1:0]  tacc;

  assign ctrl.load = (state == S_LOOP) && (m != '0) && (r1 != '0);

  mi_divstep u_divstep (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .r0   (r0),
    .r1   (r1),
    .t0   (t0),
    .t1   (t1),
    .stat (stat),
    .rem  (rem),
    .tacc (tacc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            m     <= modulus;
            r0    <= value;
            r1    <= modulus;
            t0    <= WIDTH'(1);
            t1    <= '0;
            neg0  <= 1'b0;
            busy  <= 1'b1;
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (m == '0) begin
            inverse <= '0;
            status  <= STATUS_NO_INV;
            done    <= 1'b1;
            busy    <= 1'b0;
            state   <= S_IDLE;
          end else if (r1 == '0) begin
            state <= S_FIN1;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (stat.done) begin
            r0    <= r1;
            r1    <= rem;
            t0    <= t1;
            t1    <= tacc;
            neg0  <= ~neg0;
            state <= S_LOOP;
          end
        end
        S_FIN1: begin
          if (r0 != WIDTH'(1)) begin
            inverse <= '0;
            status  <= STATUS_NO_INV;
            done    <= 1'b1;
            busy    <= 1'b0;
            state   <= S_IDLE;
          end else begin
            inv   <= (neg0 && t0 != '0) ? m - t0 : t0;
            state <= S_FIN2;
          end
        end
        S_FIN2: begin
          inverse <= (inv >= m) ? inv - m : inv;
          status  <= STATUS_OK;
          done    <= 1'b1;
          busy    <= 1'b0;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/mi_divstep.sv */
// Shift-subtract unit: one Euclid quotient step with the coefficient update.
module mi_divstep (
  input  logic                       clk,
  input  logic                       rst,
  input  mi_pkg::mi_step_ctrl_t      ctrl,
  input  logic [mi_pkg::WIDTH-1:0]   r0,
  input  logic [mi_pkg::WIDTH-1:0]   r1,
  input  logic [mi_pkg::WIDTH-1:0]   t0,
  input  logic [mi_pkg::WIDTH-1:0]   t1,
  output mi_pkg::mi_step_stat_t      stat,
  output logic [mi_pkg::WIDTH-1:0]   rem,
  output logic [mi_pkg::WIDTH-1:0]   tacc
);
  import mi_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALIGN,
    S_SUB
  } state_t;

  state_t              state;
  logic [WIDTH-1:0]    div;
  logic [WIDTH-1:0]    tsh;
  logic [CNT_W-1:0]    k;
  logic                fits_twice;
  logic                fits;

  assign fits_twice = {div, 1'b0} <= {1'b0, rem};
  assign fits       = div <= rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctrl.load) begin
            rem   <= r0;
            div   <= r1;
            tsh   <= t1;
            tacc  <= t0;
            k     <= '0;
            state <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (fits_twice) begin
            div <= {div[WIDTH-2:0], 1'b0};
            tsh <= {tsh[WIDTH-2:0], 1'b0};
            k   <= k + 1'b1;
          end else begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (fits) begin
            rem  <= rem - div;
            tacc <= tacc + tsh;
          end
          if (k == '0) begin
            stat.done <= 1'b1;
            state     <= S_IDLE;
          end else begin
            div <= {1'b0, div[WIDTH-1:1]};
            tsh <= {1'b0, tsh[WIDTH-1:1]};
            k   <= k - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/mi_checker.sv */
// Checker: port-level properties of the modular inverse block, bound to the top level.
module mi_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      done,
  input  logic [mi_pkg::WIDTH-1:0]  inverse,
  input  logic                      status
);
  import mi_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in flight");

  a_busy_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_no_inv_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_NO_INV |-> inverse == '0)
    else $error("nonzero inverse with no_inverse status");

endmodule

bind modular_inverse mi_checker u_mi_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .inverse (inverse),
  .status  (status)
);

/* bench/modular_inverse_tb.sv */
// Testbench for modular_inverse: directed and random value/modulus pairs checked against an Euclid predictor.
module modular_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mi_pkg::*;

  typedef logic [WIDTH-1:0] word_t;

  typedef struct {
    word_t value;
    word_t modulus;
    word_t inverse;
    logic  status;
  } inverse_txn_t;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam word_t       WORD_MAX    = '1;
  localparam word_t       PRIME_TOP   = word_t'(32'd4294967291);
  localparam word_t       FIB_47      = word_t'(32'd2971215073);
  localparam word_t       FIB_46      = word_t'(32'd1836311903);

  logic  clk;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic  busy;
  word_t value = '0;
  word_t modulus = '0;
  logic  done;
  word_t inverse;
  logic  status;

  inverse_txn_t pending_inverses[$];
  int unsigned  errors = 0;
  int unsigned  sent_count = 0;
  int unsigned  found_count = 0;
  int unsigned  none_count = 0;
  int unsigned  gap_pct = 0;
  int unsigned  quiet_cycles = 0;

  modular_inverse i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .value   (value),
    .modulus (modulus),
    .done    (done),
    .inverse (inverse),
    .status  (status)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic inverse_txn_t euclid_inverse(word_t v, word_t m);
    inverse_txn_t t;
    word_t        r_prev, r_cur, r_next;
    word_t        c_prev, c_cur, c_next;
    word_t        q;
    bit           c_neg;
    int           step;
    t.value   = v;
    t.modulus = m;
    t.inverse = '0;
    t.status  = STATUS_NO_INV;
    if (m == '0) begin
      return t;
    end
    r_prev = m;
    r_cur  = v % m;
    c_prev = '0;
    c_cur  = word_t'(1);
    c_neg  = 1'b0;
    for (step = 0; step < 2 * WIDTH + 4 && r_cur != '0; step++) begin
      q      = r_prev / r_cur;
      r_next = r_prev - q * r_cur;
      c_next = c_prev + q * c_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      c_prev = c_cur;
      c_cur  = c_next;
      c_neg  = !c_neg;
    end
    if (r_prev != word_t'(1)) begin
      return t;
    end
    if (!c_neg && c_prev != '0) begin
      t.inverse = m - c_prev;
    end else begin
      t.inverse = c_prev;
    end
    if (t.inverse >= m) begin
      t.inverse = t.inverse - m;
    end
    t.status = STATUS_OK;
    return t;
  endfunction

  function automatic word_t rand_word(int unsigned len);
    word_t w;
    w = word_t'({$urandom(), $urandom()});
    if (len < WIDTH) begin
      w = w >> (WIDTH - len);
    end
    return w;
  endfunction

  task automatic send_pair(word_t v, word_t m);
    value   <= v;
    modulus <= m;
    start   <= ($urandom_range(99) >= gap_pct);
    forever begin
      @(posedge clk);
      if (start && !busy) begin
        break;
      end
      start <= ($urandom_range(99) >= gap_pct);
    end
    pending_inverses.push_back(euclid_inverse(v, m));
    sent_count++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_inverses.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_degenerate_moduli();
    send_pair('0, '0);
    send_pair(WORD_MAX, '0);
    send_pair(word_t'(5), '0);
    send_pair('0, word_t'(1));
    send_pair(WORD_MAX, word_t'(1));
    send_pair('0, word_t'(7));
    send_pair(word_t'(1), word_t'(2));
    send_pair('0, WORD_MAX);
    drain_results();
  endtask

  task automatic test_value_reduction();
    send_pair(word_t'(100), word_t'(7));
    send_pair(WORD_MAX, WORD_MAX - word_t'(1));
    send_pair(WORD_MAX, WORD_MAX);
    send_pair(word_t'(7), word_t'(7));
    send_pair(word_t'(14), word_t'(7));
    send_pair(WORD_MAX, word_t'(2));
    drain_results();
  endtask

  task automatic test_operand_extremes();
    send_pair(word_t'(1), WORD_MAX);
    send_pair(WORD_MAX - word_t'(1), WORD_MAX);
    send_pair(word_t'(2), PRIME_TOP);
    send_pair(word_t'(32'h8000_0000), PRIME_TOP);
    send_pair(FIB_47, FIB_46);
    send_pair(FIB_46, FIB_47);
    send_pair(word_t'(6), word_t'(9));
    send_pair(word_t'(32'h5555_5555), word_t'(32'hAAAA_AAAA));
    send_pair(word_t'(3), word_t'(32'h8000_0000));
    drain_results();
  endtask

  task automatic test_random_pairs(int unsigned count, int unsigned idle_pct);
    word_t       v, m, g;
    int unsigned pick;
    gap_pct = idle_pct;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        v = rand_word($urandom_range(1, WIDTH));
        m = rand_word($urandom_range(1, WIDTH));
      end else if (pick < 70) begin
        v = rand_word(WIDTH);
        m = rand_word(WIDTH);
      end else if (pick < 85) begin
        g = word_t'($urandom_range(2, 1000));
        v = rand_word(WIDTH);
        m = rand_word(WIDTH);
        v = v - v % g;
        m = m - m % g;
      end else if (pick < 93) begin
        v = rand_word(WIDTH);
        m = rand_word($urandom_range(1, WIDTH / 2));
      end else begin
        v = rand_word($urandom_range(1, WIDTH));
        m = word_t'($urandom_range(2));
      end
      if (n == count / 2) begin
        drain_results();
      end
      send_pair(v, m);
    end
    drain_results();
  endtask

  always @(posedge clk) begin : result_check
    inverse_txn_t want;
    if (!rst && done) begin
      if (pending_inverses.size() == 0) begin
        $display("%0t: unexpected transaction, inverse %h status %b", $time, inverse, status);
        errors++;
      end else begin
        want = pending_inverses.pop_front();
        if (inverse !== want.inverse) begin
          $display("%0t: inverse of %h mod %h: expected %h, actual %h", $time,
                   want.value, want.modulus, want.inverse, inverse);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status of %h mod %h: expected %b, actual %b", $time,
                   want.value, want.modulus, want.status, status);
          errors++;
        end
        if (want.status == STATUS_OK) begin
          found_count++;
        end else begin
          none_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    gap_pct = 7;
    test_degenerate_moduli();
    test_value_reduction();
    test_operand_extremes();
    test_random_pairs(150, 7);
    test_random_pairs(150, 64);
    test_random_pairs(150, 0);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_inverses.size() != 0) begin
      $display("%0t: %0d transactions never returned", $time, pending_inverses.size());
      errors++;
    end
    $display("Sent %0d value/modulus pairs: %0d had an inverse, %0d had none.",
             sent_count, found_count, none_count);
    $display("Sender gaps of 7, 64 and 0 percent; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
